### rtl/dec_pkg.sv
// Shared constants and types for the density effect correction pipeline.
`default_nettype none

package dec_pkg;

  localparam int FRAC_BITS = 16;
  localparam int BASE_W = 26;
  localparam int T_W = 43;
  localparam int SUM_W = 34;
  localparam int POW_W = 41;
  localparam int COEF_W = 18;
  localparam int LOG_STEPS = 32;
  localparam int SERIES_TERMS = 16;
  localparam int LATENCY = 89;

  localparam logic [34:0] TWO_LN10_Q32 = 35'd19779055341;
  localparam logic [34:0] LOG2_100_Q32 = 35'd28535145054;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [POW_W-1:0] POW_CAP = 41'h10000000000;
  localparam logic [19:0] EXPONENT_M_RESET = 20'd196608;

  typedef enum logic [2:0] {
    CFG_LOWER_KNEE = 3'd0,
    CFG_UPPER_KNEE = 3'd1,
    CFG_OFFSET_C   = 3'd2,
    CFG_COEFF_A    = 3'd3,
    CFG_EXPONENT_M = 3'd4,
    CFG_DELTA0     = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    REGION_LOW  = 2'd0,
    REGION_MID  = 2'd1,
    REGION_HIGH = 2'd2
  } region_t;

  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    region_t                  region;
  } side_t;

  typedef struct packed {
    side_t                    side;
    logic [COEF_W-1:0]        coef;
    logic signed [T_W-1:0]    tlow;
    logic signed [5:0]        expo;
  } log_carry_t;

endpackage

`default_nettype wire

### rtl/density_effect_correction_top.sv
// Top level of the pipelined density effect correction unit.
//
//   Channel   Handshake            Payload
//   input     start / busy         log_beta_gamma
//   result    done (strobe)        correction, region
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word enters per cycle.
// The depth is set by the 32 squaring stages of the logarithm and the
// 16 three-stage terms of the exponential series.
// Reset is synchronous; busy and cfg_ready follow rst.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none

module density_effect_correction_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [20:0] log_beta_gamma,
  output logic               done,
  output logic signed [23:0] correction,
  output logic [1:0]         region,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data
);

  logic signed [20:0] lower_knee;
  logic [19:0]        upper_knee;
  logic [21:0]        offset_c;
  logic [17:0]        coeff_a;
  logic [19:0]        exponent_m;
  logic [16:0]        conductor_delta0;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_knee       <= '0;
      upper_knee       <= '0;
      offset_c         <= '0;
      coeff_a          <= '0;
      exponent_m       <= dec_pkg::EXPONENT_M_RESET;
      conductor_delta0 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dec_pkg::cfg_index_t'(cfg_index))
        dec_pkg::CFG_LOWER_KNEE: lower_knee       <= $signed(cfg_data[20:0]);
        dec_pkg::CFG_UPPER_KNEE: upper_knee       <= cfg_data[19:0];
        dec_pkg::CFG_OFFSET_C:   offset_c         <= cfg_data;
        dec_pkg::CFG_COEFF_A:    coeff_a          <= cfg_data[17:0];
        dec_pkg::CFG_EXPONENT_M: exponent_m       <= cfg_data[19:0];
        dec_pkg::CFG_DELTA0:     conductor_delta0 <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic                       accept;
  logic signed [21:0]         x_ext;
  logic                       below;
  logic                       at_top;
  dec_pkg::region_t           region_in;
  logic [dec_pkg::COEF_W-1:0] coef_in;

  assign accept = start && !busy;
  assign x_ext  = {log_beta_gamma[20], log_beta_gamma};
  assign below  = log_beta_gamma < lower_knee;
  assign at_top = x_ext >= $signed({2'b00, upper_knee});

  always_comb begin
    if (below) begin
      region_in = dec_pkg::REGION_LOW;
      coef_in   = {1'b0, conductor_delta0};
    end else if (at_top) begin
      region_in = dec_pkg::REGION_HIGH;
      coef_in   = '0;
    end else begin
      region_in = dec_pkg::REGION_MID;
      coef_in   = coeff_a;
    end
  end

  logic                       f1_valid;
  logic signed [20:0]         f1_x;
  dec_pkg::region_t           f1_region;
  logic [20:0]                f1_d;
  logic signed [21:0]         f1_dlow;
  logic [dec_pkg::COEF_W-1:0] f1_coef;
  logic [21:0]                d_full;

  assign d_full = {2'b00, upper_knee} - x_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    f1_x      <= log_beta_gamma;
    f1_region <= region_in;
    f1_d      <= d_full[20:0];
    f1_dlow   <= x_ext - {lower_knee[20], lower_knee};
    f1_coef   <= coef_in;
  end

  logic [4:0]                 top_bit;
  logic [31:0]                mant_in;
  logic                       f2_valid;
  dec_pkg::region_t           f2_region;
  logic [dec_pkg::COEF_W-1:0] f2_coef;
  logic signed [56:0]         f2_lin_prod;
  logic signed [57:0]         f2_tlow_prod;
  logic [31:0]                f2_mant;
  logic signed [5:0]          f2_expo;

  always_comb begin
    top_bit = '0;
    for (int i = 0; i < 21; i++) begin
      if (f1_d[i]) begin
        top_bit = 5'(i);
      end
    end
    mant_in = 32'(f1_d) << (5'd31 - top_bit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f2_region    <= f1_region;
    f2_coef      <= f1_coef;
    f2_lin_prod  <= f1_x * $signed({1'b0, dec_pkg::TWO_LN10_Q32});
    f2_tlow_prod <= f1_dlow * $signed({1'b0, dec_pkg::LOG2_100_Q32});
    f2_mant      <= mant_in;
    f2_expo      <= $signed({1'b0, top_bit}) - 6'(dec_pkg::FRAC_BITS);
  end

  logic signed [56:0]         lin_round;
  logic signed [24:0]         lin;
  logic signed [25:0]         base_in;
  logic                       f3_valid;
  logic [31:0]                f3_mant;
  dec_pkg::log_carry_t        f3_carry;

  always_comb begin
    lin_round = f2_lin_prod + 57'sd2147483648;
    lin       = lin_round[56:32];
    if (f2_region == dec_pkg::REGION_LOW) begin
      base_in = '0;
    end else begin
      base_in = {lin[24], lin} - $signed({4'b0000, offset_c});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else begin
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    f3_mant              <= f2_mant;
    f3_carry.side.base   <= base_in;
    f3_carry.side.region <= f2_region;
    f3_carry.coef        <= f2_coef;
    f3_carry.tlow        <= {f2_tlow_prod[57], f2_tlow_prod[57:16]};
    f3_carry.expo        <= f2_expo;
  end

  logic                lp_valid;
  logic [31:0]         lp_frac;
  dec_pkg::log_carry_t lp_carry;

  dec_log_pipe u_log (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f3_valid),
    .in_mant   (f3_mant),
    .in_carry  (f3_carry),
    .out_valid (lp_valid),
    .out_frac  (lp_frac),
    .out_carry (lp_carry)
  );

  logic signed [37:0]  log_val;
  logic                m1_valid;
  logic signed [58:0]  m1_prod;
  dec_pkg::log_carry_t m1_carry;

  assign log_val = {lp_carry.expo, lp_frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= lp_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_prod  <= $signed({1'b0, exponent_m}) * log_val;
    m1_carry <= lp_carry;
  end

  logic                              m2_valid;
  logic signed [dec_pkg::T_W-1:0]    m2_t;
  logic [dec_pkg::COEF_W-1:0]        m2_coef;
  dec_pkg::side_t                    m2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_carry.side.region == dec_pkg::REGION_MID) begin
      m2_t <= m1_prod[58:16];
    end else begin
      m2_t <= m1_carry.tlow;
    end
    m2_coef <= m1_carry.coef;
    m2_side <= m1_carry.side;
  end

  logic                        pp_valid;
  logic [dec_pkg::POW_W-1:0]   pp_pow;
  dec_pkg::side_t              pp_side;

  dec_pow_pipe u_pow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m2_valid),
    .in_t      (m2_t),
    .in_coef   (m2_coef),
    .in_side   (m2_side),
    .out_valid (pp_valid),
    .out_pow   (pp_pow),
    .out_side  (pp_side)
  );

  logic signed [42:0] y;
  logic signed [23:0] y_sat;

  always_comb begin
    y = $signed({{17{pp_side.base[25]}}, pp_side.base}) + $signed({2'b00, pp_pow});
    if (y > 43'sd8388607) begin
      y_sat = 24'sh7FFFFF;
    end else if (y < -43'sd8388608) begin
      y_sat = 24'sh800000;
    end else begin
      y_sat = y[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pp_valid;
    end
  end

  always_ff @(posedge clk) begin
    correction <= y_sat;
    region     <= pp_side.region;
  end

endmodule

`default_nettype wire

### rtl/dec_log_pipe.sv
// Pipelined base-2 logarithm fraction: one squaring step per stage.
`default_nettype none

module dec_log_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         in_mant,
  input  dec_pkg::log_carry_t in_carry,
  output logic                out_valid,
  output logic [31:0]         out_frac,
  output dec_pkg::log_carry_t out_carry
);

  localparam int N = dec_pkg::LOG_STEPS;

  logic                valid [0:N];
  logic [31:0]         mant  [0:N];
  logic [31:0]         frac  [0:N];
  dec_pkg::log_carry_t carry [0:N];

  assign valid[0] = in_valid;
  assign mant[0]  = in_mant;
  assign frac[0]  = '0;
  assign carry[0] = in_carry;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [63:0] sq;
    logic [32:0] sq_top;

    assign sq     = mant[i] * mant[i];
    assign sq_top = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (sq_top[32]) begin
        mant[i+1] <= sq_top[32:1];
        frac[i+1] <= frac[i] | (32'd1 << (31 - i));
      end else begin
        mant[i+1] <= sq_top[31:0];
        frac[i+1] <= frac[i];
      end
      carry[i+1] <= carry[i];
    end
  end

  assign out_valid = valid[N];
  assign out_frac  = frac[N];
  assign out_carry = carry[N];

endmodule

`default_nettype wire

### rtl/dec_pow_pipe.sv
// Pipelined coef times two to a Q32 power, rounded and capped.
`default_nettype none

module dec_pow_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [dec_pkg::T_W-1:0]   in_t,
  input  logic [dec_pkg::COEF_W-1:0]       in_coef,
  input  dec_pkg::side_t                   in_side,
  output logic                             out_valid,
  output logic [dec_pkg::POW_W-1:0]        out_pow,
  output dec_pkg::side_t                   out_side
);

  localparam int NT = dec_pkg::SERIES_TERMS;

  typedef struct packed {
    dec_pkg::side_t                side;
    logic signed [10:0]            n;
    logic [dec_pkg::COEF_W-1:0]    coef;
    logic [31:0]                   z;
    logic [dec_pkg::SUM_W-1:0]     sum;
  } pow_carry_t;

  logic        p0_valid;
  pow_carry_t  p0_car;
  logic [63:0] zp;

  assign zp = in_t[31:0] * dec_pkg::LN2_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p0_car.side <= in_side;
    p0_car.n    <= in_t[dec_pkg::T_W-1:32];
    p0_car.coef <= in_coef;
    p0_car.z    <= zp[63:32];
    p0_car.sum  <= 34'h100000000;
  end

  logic        valid [0:NT];
  logic [32:0] term  [0:NT];
  pow_carry_t  car   [0:NT];

  assign valid[0] = p0_valid;
  assign term[0]  = 33'h100000000;
  assign car[0]   = p0_car;

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int K = j + 1;
    localparam logic [36:0] RECIP = 37'((64'd1 << 36) / K);

    logic        a_valid;
    logic [31:0] a_v;
    pow_carry_t  a_car;
    logic        b_valid;
    logic [31:0] b_v;
    logic [31:0] b_qm;
    pow_carry_t  b_car;
    logic [63:0] tz;
    logic [68:0] vr;
    logic [31:0] qk;
    logic [31:0] rem;
    logic [31:0] q;
    pow_carry_t  car_next;

    assign tz = term[j] * car[j].z;
    assign vr = a_v * RECIP;

    always_comb begin
      qk       = 32'(b_qm * 32'(K));
      rem      = b_v - qk;
      q        = (rem >= 32'(K)) ? b_qm + 32'd1 : b_qm;
      car_next = b_car;
      car_next.sum = b_car.sum + {2'b00, q};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid    <= 1'b0;
        b_valid    <= 1'b0;
        valid[j+1] <= 1'b0;
      end else begin
        a_valid    <= valid[j];
        b_valid    <= a_valid;
        valid[j+1] <= b_valid;
      end
    end

    always_ff @(posedge clk) begin
      a_v       <= tz[63:32];
      a_car     <= car[j];
      b_v       <= a_v;
      b_qm      <= vr[67:36];
      b_car     <= a_car;
      term[j+1] <= {1'b0, q};
      car[j+1]  <= car_next;
    end
  end

  logic               p1_valid;
  logic [51:0]        p1_prod;
  logic signed [10:0] p1_n;
  dec_pkg::side_t     p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= valid[NT];
    end
  end

  always_ff @(posedge clk) begin
    p1_prod <= car[NT].coef * car[NT].sum;
    p1_n    <= car[NT].n;
    p1_side <= car[NT].side;
  end

  logic signed [11:0]         sh;
  logic signed [11:0]         neg_sh;
  logic signed [11:0]         rs;
  logic [60:0]                v;
  logic [dec_pkg::POW_W-1:0]  pow_next;

  always_comb begin
    sh       = 12'sd32 - {p1_n[10], p1_n};
    neg_sh   = -sh;
    rs       = sh - 12'sd1;
    v        = '0;
    pow_next = '0;
    if (p1_prod == '0) begin
      pow_next = '0;
    end else if (p1_n > 11'sd40) begin
      pow_next = dec_pkg::POW_CAP;
    end else if (sh >= 12'sd64) begin
      pow_next = '0;
    end else begin
      if (sh <= 12'sd0) begin
        v = 61'(p1_prod) << neg_sh[3:0];
      end else begin
        v = (61'(p1_prod >> rs[5:0]) + 61'd1) >> 1;
      end
      if (v > 61'(dec_pkg::POW_CAP)) begin
        pow_next = dec_pkg::POW_CAP;
      end else begin
        pow_next = v[dec_pkg::POW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pow  <= pow_next;
    out_side <= p1_side;
  end

endmodule

`default_nettype wire

### rtl/dec_checker.sv
// Port-level checks for the density effect correction unit, bound to the top level.
`default_nettype none

module dec_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [20:0] log_beta_gamma,
  input logic               done,
  input logic signed [23:0] correction,
  input logic [1:0]         region,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [21:0]        cfg_data
);

  localparam int LAT = dec_pkg::LATENCY;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("Accepted word produced no result at the expected cycle.");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("Result strobe without a matching accepted word.");

  a_low_region_nonneg: assert property (@(posedge clk) disable iff (rst)
    (done && region == dec_pkg::REGION_LOW) |-> !correction[23])
    else $error("Negative correction below the lower knee.");

endmodule

bind density_effect_correction_top dec_checker u_checker (.*);

`default_nettype wire

### tb/density_effect_correction_top_tb.sv
// Self-checking testbench for the density effect correction pipeline.
`timescale 1ns / 1ps

class correction_scoreboard;
  longint lower_knee;
  longint upper_knee;
  longint offset_c;
  longint coeff_a;
  longint exponent_m;
  longint delta0;
  logic [23:0] exp_correction[$];
  dec_pkg::region_t exp_region[$];
  int mismatches;

  function void reset_regs();
    lower_knee = 0;
    upper_knee = 0;
    offset_c = 0;
    coeff_a = 0;
    exponent_m = longint'(dec_pkg::EXPONENT_M_RESET);
    delta0 = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [21:0] data);
    case (idx)
      dec_pkg::CFG_LOWER_KNEE: lower_knee = longint'($signed(data[20:0]));
      dec_pkg::CFG_UPPER_KNEE: upper_knee = longint'(data[19:0]);
      dec_pkg::CFG_OFFSET_C:   offset_c = longint'(data);
      dec_pkg::CFG_COEFF_A:    coeff_a = longint'(data[17:0]);
      dec_pkg::CFG_EXPONENT_M: exponent_m = longint'(data[19:0]);
      dec_pkg::CFG_DELTA0:     delta0 = longint'(data[16:0]);
      default: ;
    endcase
  endfunction

  // Base-2 logarithm of d / 2^16 in Q32, by repeated squaring of the mantissa.
  function longint log2_q32(longint unsigned d);
    int p;
    longint unsigned mant;
    longint unsigned frac;
    p = 0;
    frac = 0;
    while (p < 31 && (d >> (p + 1)) != 0) p++;
    mant = (d << (31 - p)) & 64'hFFFF_FFFF;
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      if (mant >= (64'd1 << 32)) begin
        mant = mant >> 1;
        frac = frac | (64'd1 << (31 - i));
      end
    end
    return (longint'(p) - dec_pkg::FRAC_BITS) * (longint'(1) << 32) + longint'(frac);
  endfunction

  // coef * 2^(t / 2^32) by a truncated series, rounded and capped.
  function longint scale_pow2(longint unsigned coef, longint t);
    longint n;
    longint s;
    longint unsigned f;
    longint unsigned z;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned prod;
    longint unsigned v;
    n = t >>> 32;
    f = longint'(t) & 64'hFFFF_FFFF;
    z = (f * 64'(dec_pkg::LN2_Q32)) >> 32;
    term = 64'd1 << 32;
    sum = term;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * z) >> 32) / k;
      sum += term;
    end
    prod = coef * sum;
    if (prod == 0) return 0;
    if (n > 40) return longint'(dec_pkg::POW_CAP);
    s = 32 - n;
    if (s >= 64) return 0;
    if (s <= 0) v = prod << (-s);
    else v = (prod + (64'd1 << (s - 1))) >> s;
    return (v > 64'(dec_pkg::POW_CAP)) ? longint'(dec_pkg::POW_CAP) : longint'(v);
  endfunction

  function void note_input(logic signed [20:0] xin);
    longint x;
    longint y;
    longint t;
    dec_pkg::region_t reg_out;
    x = longint'(xin);
    y = 0;
    if (x < lower_knee) begin
      reg_out = dec_pkg::REGION_LOW;
      if (delta0 > 0) begin
        t = ((x - lower_knee) * longint'(dec_pkg::LOG2_100_Q32)) >>> dec_pkg::FRAC_BITS;
        y = scale_pow2(delta0, t);
      end
    end else begin
      y = ((x * longint'(dec_pkg::TWO_LN10_Q32) + (longint'(1) << 31)) >>> 32) - offset_c;
      if (x >= upper_knee) begin
        reg_out = dec_pkg::REGION_HIGH;
      end else begin
        reg_out = dec_pkg::REGION_MID;
        t = (exponent_m * log2_q32(upper_knee - x)) >>> dec_pkg::FRAC_BITS;
        y += scale_pow2(coeff_a, t);
      end
    end
    if (y > (longint'(1) << 23) - 1) y = (longint'(1) << 23) - 1;
    if (y < -(longint'(1) << 23)) y = -(longint'(1) << 23);
    exp_correction.push_back(y[23:0]);
    exp_region.push_back(reg_out);
  endfunction

  function void check_result(logic [23:0] corr, logic [1:0] reg_in);
    logic [23:0] ec;
    dec_pkg::region_t er;
    if (exp_correction.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result word: correction %0d region %0d",
                 $signed(corr), reg_in);
      return;
    end
    ec = exp_correction.pop_front();
    er = exp_region.pop_front();
    if (corr !== ec || reg_in !== er) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected correction %0d region %0d, got %0d region %0d",
                 $signed(ec), er, $signed(corr), reg_in);
    end
  endfunction
endclass

module density_effect_correction_top_tb;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [20:0] log_beta_gamma;
  logic done;
  logic signed [23:0] correction;
  logic [1:0] region;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [21:0] cfg_data;

  correction_scoreboard sb;
  int cycles;
  int idle_pct;

  density_effect_correction_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .log_beta_gamma(log_beta_gamma), .done(done), .correction(correction),
    .region(region), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("density_effect_correction_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_input(log_beta_gamma);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (done) sb.check_result(correction, region);
    end
  end

  task automatic send_word(logic signed [20:0] x);
    start <= 1'b1;
    log_beta_gamma <= x;
    do @(posedge clk); while (busy);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      log_beta_gamma <= 21'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.exp_correction.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [21:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(int x0, int x1, int c, int a, int m, int d0);
    write_reg(dec_pkg::CFG_LOWER_KNEE, 22'(x0));
    write_reg(dec_pkg::CFG_UPPER_KNEE, 22'(x1));
    write_reg(dec_pkg::CFG_OFFSET_C, 22'(c));
    write_reg(dec_pkg::CFG_COEFF_A, 22'(a));
    write_reg(dec_pkg::CFG_EXPONENT_M, 22'(m));
    write_reg(dec_pkg::CFG_DELTA0, 22'(d0));
  endtask

  function automatic logic signed [20:0] pick_x();
    case ($urandom_range(9))
      0: return 21'($urandom);
      1, 2: return 21'(sb.lower_knee + $urandom_range(8192) - 4096);
      3, 4: return 21'(sb.upper_knee + $urandom_range(8192) - 4096);
      default: return 21'($urandom_range(1048576) - 524288);
    endcase
  endfunction

  initial begin
    sb = new();
    sb.reset_regs();
    cycles = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    log_beta_gamma = '0;
    cfg_valid = 1'b0;
    cfg_index = dec_pkg::CFG_LOWER_KNEE;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, then a typical material with a conductor tail.
    send_word(21'sd0);
    send_word(21'sd65536);
    send_word(-21'sd65536);
    drain();
    load_config(-65536, 196608, 262144, 32768, 196608, 6554);
    write_reg(CFG_UNUSED, 22'h3FFFFF);
    send_word(-21'sd524288);
    send_word(21'sd524288);
    send_word(-21'sd1048576);
    send_word(21'sd1048575);
    send_word(-21'sd65536);
    send_word(-21'sd65537);
    send_word(21'sd196607);
    send_word(21'sd196608);
    send_word(21'sd0);
    drain();
    // Inverted knees and no conductor tail.
    load_config(524288, 0, 0, 131072, 65536, 0);
    send_word(21'sd524287);
    send_word(21'sd524288);
    send_word(-21'sd524288);
    drain();
    // Widest span, largest parameters, then a zero exponent.
    load_config(-131072, 524288, 2097152, 131072, 524288, 65536);
    send_word(-21'sd131072);
    send_word(-21'sd524288);
    send_word(21'sd524287);
    send_word(21'sd1048575);
    drain();
    write_reg(dec_pkg::CFG_EXPONENT_M, 22'd0);
    send_word(21'sd0);
    send_word(21'sd100000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 30 : 0;
      if (ph == 5)
        load_config(-131072, 524288, 0, 131072, 524288, 65536);
      else
        load_config($urandom_range(655360) - 131072, $urandom_range(524288),
                    $urandom_range(2097152), $urandom_range(131072),
                    $urandom_range(65536, 524288),
                    $urandom_range(3) == 0 ? 0 : $urandom_range(65536));
      for (int i = 0; i < 165; i++) begin
        send_word(pick_x());
        if (ph == 2 && i == 80) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.exp_correction.size() == 0) begin
      $display("density_effect_correction_top verification clean");
    end else begin
      $display("density_effect_correction_top verification failed");
    end
    $finish;
  end
endmodule
